@@ hw/rtl/lpg_pkg.sv @@
`default_nettype none

package lpg_pkg;

  localparam int LEVELS_DEFAULT  = 8;
  localparam int ID_BITS_DEFAULT = 8;

  localparam int LANE_BITS      = 8;
  localparam int LANES_MAX      = 8;
  localparam int GRANT_BITS     = 8;
  localparam int LEN_BITS       = 4;
  localparam int IDS_BITS       = LANE_BITS * LANES_MAX;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 64;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEFAULT_GRANT = 2'd0,
    REG_LABEL_LENGTH  = 2'd1,
    REG_LABEL_IDS     = 2'd2,
    REG_LEVEL_BITS    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GRANT_BITS-1:0] default_grant;
    logic [LEN_BITS-1:0]   label_length;
    logic [IDS_BITS-1:0]   label_ids;
    logic [IDS_BITS-1:0]   label_level_bits;
  } label_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/label_prefix_permission_grant.sv @@
// Pipeline: input register, one compare/OR pass, result register.
// Throughput: one slot beat per cycle while in_stall is low.
// The input stalls only while a last slot waits behind an output beat that is stalled.
// Reset (rst, synchronous, active high) clears the configuration registers,
// the grant accumulator and both valid flags.
`default_nettype none

module label_prefix_permission_grant #(
  parameter int LEVELS  = lpg_pkg::LEVELS_DEFAULT,
  parameter int ID_BITS = lpg_pkg::ID_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [lpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               slot_active,
  input  wire logic [lpg_pkg::LEN_BITS-1:0]       slot_length,
  input  wire logic [lpg_pkg::IDS_BITS-1:0]       slot_ids,
  input  wire logic                               last_slot,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [lpg_pkg::GRANT_BITS-1:0]     granted
);

  lpg_pkg::label_cfg_t cfg;

  logic                            s1_valid;
  logic                            s1_active;
  logic [lpg_pkg::LEN_BITS-1:0]    s1_length;
  logic [lpg_pkg::IDS_BITS-1:0]    s1_ids;
  logic                            s1_last;
  logic [lpg_pkg::GRANT_BITS-1:0]  s1_grant;
  logic [lpg_pkg::GRANT_BITS-1:0]  acc;
  logic [lpg_pkg::GRANT_BITS-1:0]  acc_next;
  logic                            s1_blocked;
  logic                            s1_fire;
  logic                            in_fire;

  lpg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpg_slot_grant #(
    .LEVELS  (LEVELS),
    .ID_BITS (ID_BITS)
  ) u_slot_grant (
    .cfg         (cfg),
    .slot_active (s1_active),
    .slot_length (s1_length),
    .slot_ids    (s1_ids),
    .grant       (s1_grant)
  );

  // a last slot needs a free output register
  assign s1_blocked = s1_last && out_valid && out_stall;
  assign s1_fire    = s1_valid && !s1_blocked;
  assign in_stall   = s1_valid && s1_blocked;
  assign in_fire    = in_valid && !in_stall;
  assign acc_next   = acc | s1_grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_active <= slot_active;
      s1_length <= slot_length;
      s1_ids    <= slot_ids;
      s1_last   <= last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        if (s1_last) begin
          acc       <= '0;
          out_valid <= 1'b1;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      granted <= acc_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lpg_cfg_regs.sv @@
`default_nettype none

module lpg_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [lpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output lpg_pkg::label_cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (lpg_pkg::cfg_reg_t'(cfg_index))
        lpg_pkg::REG_DEFAULT_GRANT: cfg.default_grant    <= cfg_data[lpg_pkg::GRANT_BITS-1:0];
        lpg_pkg::REG_LABEL_LENGTH:  cfg.label_length     <= cfg_data[lpg_pkg::LEN_BITS-1:0];
        lpg_pkg::REG_LABEL_IDS:     cfg.label_ids        <= cfg_data[lpg_pkg::IDS_BITS-1:0];
        lpg_pkg::REG_LEVEL_BITS:    cfg.label_level_bits <= cfg_data[lpg_pkg::IDS_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lpg_slot_grant.sv @@
`default_nettype none

module lpg_slot_grant #(
  parameter int LEVELS  = lpg_pkg::LEVELS_DEFAULT,
  parameter int ID_BITS = lpg_pkg::ID_BITS_DEFAULT
) (
  input  wire lpg_pkg::label_cfg_t              cfg,
  input  wire logic                             slot_active,
  input  wire logic [lpg_pkg::LEN_BITS-1:0]     slot_length,
  input  wire logic [lpg_pkg::IDS_BITS-1:0]     slot_ids,
  output logic      [lpg_pkg::GRANT_BITS-1:0]   grant
);

  logic [lpg_pkg::LEN_BITS-1:0] label_len_eff;

  // label longer than the level count (LEVELS) is cut to the level count
  assign label_len_eff = (cfg.label_length > lpg_pkg::LEN_BITS'(LEVELS))
                         ? lpg_pkg::LEN_BITS'(LEVELS) : cfg.label_length;

  always_comb begin
    logic run;
    logic in_slot;
    logic id_match;
    run   = 1'b1;
    grant = cfg.default_grant;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      in_slot  = lpg_pkg::LEN_BITS'(lvl) < slot_length;
      id_match = cfg.label_ids[lvl*lpg_pkg::LANE_BITS +: ID_BITS]
                 == slot_ids[lvl*lpg_pkg::LANE_BITS +: ID_BITS];
      // past the end of the slot every level passes (prefix case)
      run = run & (~in_slot | id_match);
      if (run && (lpg_pkg::LEN_BITS'(lvl) < label_len_eff)) begin
        grant = grant | cfg.label_level_bits[lvl*lpg_pkg::LANE_BITS +: lpg_pkg::GRANT_BITS];
      end
    end
    if (!slot_active) begin
      grant = '0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lpg_checker.sv @@
`default_nettype none

module lpg_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               cfg_write,
  input wire logic [lpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input wire logic [lpg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic                               slot_active,
  input wire logic [lpg_pkg::LEN_BITS-1:0]       slot_length,
  input wire logic [lpg_pkg::IDS_BITS-1:0]       slot_ids,
  input wire logic                               last_slot,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [lpg_pkg::GRANT_BITS-1:0]     granted
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(granted))
    else $error("output beat changed while stalled");

  // input backpressure only comes from a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output beat");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_reset_in: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind label_prefix_permission_grant lpg_checker u_lpg_checker (.*);

`default_nettype wire

@@ sim/tb_label_prefix_permission_grant.sv @@
`timescale 1ns / 100ps

module tb_label_prefix_permission_grant;
  import lpg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int PHASES = 8;

  class grant_scoreboard;
    logic [GRANT_BITS-1:0] dflt_grant;
    logic [LEN_BITS-1:0]   lbl_len;
    logic [IDS_BITS-1:0]   lbl_ids;
    logic [IDS_BITS-1:0]   lvl_bits;
    logic [GRANT_BITS-1:0] acc;
    logic [GRANT_BITS-1:0] expected_grants[$];
    int errors;
    int slots_seen;
    int grants_checked;

    function new();
      dflt_grant = '0;
      lbl_len = '0;
      lbl_ids = '0;
      lvl_bits = '0;
      acc = '0;
      errors = 0;
      slots_seen = 0;
      grants_checked = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        REG_DEFAULT_GRANT: dflt_grant = v[GRANT_BITS-1:0];
        REG_LABEL_LENGTH:  lbl_len = v[LEN_BITS-1:0];
        REG_LABEL_IDS:     lbl_ids = v[IDS_BITS-1:0];
        REG_LEVEL_BITS:    lvl_bits = v[IDS_BITS-1:0];
        default: ;
      endcase
    endfunction

    // default bits, then each level while ids agree; a slot that runs out
    // of ids first is a prefix and earns every remaining level
    function logic [GRANT_BITS-1:0] slot_grant(logic [LEN_BITS-1:0] slen,
                                               logic [IDS_BITS-1:0] sids);
      int depth;
      logic [GRANT_BITS-1:0] g;
      logic [LANE_BITS-1:0] idmask;
      depth = (int'(lbl_len) > LEVELS_DEFAULT) ? LEVELS_DEFAULT : int'(lbl_len);
      idmask = LANE_BITS'((1 << ID_BITS_DEFAULT) - 1);
      g = dflt_grant;
      for (int lvl = 0; lvl < depth; lvl++) begin
        if (lvl < int'(slen) &&
            ((lbl_ids[lvl*LANE_BITS +: LANE_BITS] ^ sids[lvl*LANE_BITS +: LANE_BITS])
             & idmask) != '0)
          break;
        g |= lvl_bits[lvl*LANE_BITS +: LANE_BITS];
      end
      return g;
    endfunction

    function void note_slot(logic active, logic [LEN_BITS-1:0] slen,
                            logic [IDS_BITS-1:0] sids, logic last);
      slots_seen++;
      if (active)
        acc |= slot_grant(slen, sids);
      if (last) begin
        expected_grants.push_back(acc);
        acc = '0;
      end
    endfunction

    function void check_grant(logic [GRANT_BITS-1:0] got);
      logic [GRANT_BITS-1:0] want;
      grants_checked++;
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: grant %h with no query pending", got);
        return;
      end
      want = expected_grants.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: granted expected %h actual %h", want, got);
      end
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  cfg_reg_t                  cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      slot_active;
  logic [LEN_BITS-1:0]       slot_length;
  logic [IDS_BITS-1:0]       slot_ids;
  logic                      last_slot;
  logic                      out_valid;
  logic                      out_stall;
  logic [GRANT_BITS-1:0]     granted;

  grant_scoreboard sb = new();

  int send_idle_pct;
  int stall_pct;
  int hold_cycles;
  int cycles;
  int configs_used;
  logic [IDS_BITS-1:0] cur_label_ids;

  label_prefix_permission_grant dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .slot_active (slot_active),
    .slot_length (slot_length),
    .slot_ids    (slot_ids),
    .last_slot   (last_slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .granted     (granted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_label_prefix_permission_grant: errors");
      $finish;
    end
  end

  // beat monitors
  always @(posedge clk) begin
    if (!rst && in_valid === 1'b1 && in_stall === 1'b0)
      sb.note_slot(slot_active, slot_length, slot_ids, last_slot);
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_grant(granted);
  end

  // receiver; a requested hold-off is counted down here
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_slot(input logic a, input logic [LEN_BITS-1:0] len,
                           input logic [IDS_BITS-1:0] ids, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    slot_active <= a;
    slot_length <= len;
    slot_ids    <= ids;
    last_slot   <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // non-last slots may still be in the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_label(input logic [GRANT_BITS-1:0] dg, input logic [LEN_BITS-1:0] len,
                             input logic [IDS_BITS-1:0] ids, input logic [IDS_BITS-1:0] bits);
    put_reg(REG_DEFAULT_GRANT, CFG_DATA_BITS'(dg));
    put_reg(REG_LABEL_LENGTH, CFG_DATA_BITS'(len));
    put_reg(REG_LABEL_IDS, CFG_DATA_BITS'(ids));
    put_reg(REG_LEVEL_BITS, CFG_DATA_BITS'(bits));
    cfg_write <= 1'b0;
    cur_label_ids = ids;
    configs_used++;
  endtask

  // ids that agree with the label below lane depth and differ at lane depth
  function automatic logic [IDS_BITS-1:0] match_ids(int depth);
    logic [IDS_BITS-1:0] ids;
    ids = {$urandom(), $urandom()};
    for (int lvl = 0; lvl < LANES_MAX; lvl++) begin
      if (lvl < depth)
        ids[lvl*LANE_BITS +: LANE_BITS] = cur_label_ids[lvl*LANE_BITS +: LANE_BITS];
      else if (lvl == depth)
        ids[lvl*LANE_BITS +: LANE_BITS] = cur_label_ids[lvl*LANE_BITS +: LANE_BITS]
                                          ^ LANE_BITS'($urandom_range(1, 255));
    end
    return ids;
  endfunction

  task automatic random_query();
    int nslots;
    int depth;
    logic [LEN_BITS-1:0] len;
    logic [IDS_BITS-1:0] ids;
    logic a;
    logic last;
    nslots = $urandom_range(1, 4);
    for (int k = 0; k < nslots; k++) begin
      a = ($urandom_range(99) < 85);
      depth = $urandom_range(0, LANES_MAX);
      case ($urandom_range(9))
        0:       len = LEN_BITS'($urandom_range(9, 15));
        1, 2:    len = LEN_BITS'(depth);
        default: len = LEN_BITS'($urandom_range(0, LANES_MAX));
      endcase
      ids = ($urandom_range(9) == 0) ? {$urandom(), $urandom()} : match_ids(depth);
      last = (k == nslots - 1) ? 1'b1 : ($urandom_range(19) == 0);
      send_slot(a, len, ids, last);
    end
  endtask

  task automatic random_label(input int ph);
    logic [GRANT_BITS-1:0] dg;
    logic [LEN_BITS-1:0] len;
    logic [IDS_BITS-1:0] ids;
    logic [IDS_BITS-1:0] bits;
    dg = (ph == 5) ? '1 : ($urandom_range(1) ? GRANT_BITS'($urandom_range(255)) : '0);
    case (ph)
      1:       len = '0;
      3:       len = LEN_BITS'($urandom_range(9, 15));
      6:       len = LEN_BITS'(LANES_MAX);
      default: len = LEN_BITS'($urandom_range(1, LANES_MAX));
    endcase
    ids = (ph == 7) ? '0 : {$urandom(), $urandom()};
    bits = (ph == 4) ? '1 : {$urandom(), $urandom()};
    write_label(dg, len, ids, bits);
  endtask

  initial begin
    int n;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    cycles = 0;
    configs_used = 0;
    cur_label_ids = '0;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_DEFAULT_GRANT;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    slot_active <= 1'b0;
    slot_length <= '0;
    slot_ids    <= '0;
    last_slot   <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one level bit per lane so each grant shows how deep it got
    write_label(8'h00, 4'd5, 64'hF0E1_D2C3_B4A5_9687, 64'h8040_2010_0804_0201);
    send_slot(1'b0, 4'd0, '0, 1'b1);          // no active slot
    send_slot(1'b1, 4'd0, {$urandom(), $urandom()}, 1'b1);
    send_slot(1'b1, 4'd8, match_ids(8), 1'b1);
    send_slot(1'b1, 4'd8, match_ids(0), 1'b1);
    send_slot(1'b1, 4'd8, match_ids(2), 1'b1);
    send_slot(1'b1, 4'd2, match_ids(2), 1'b1); // prefix of the label
    send_slot(1'b1, 4'd3, match_ids(1), 1'b1);
    send_slot(1'b1, 4'd15, match_ids(8), 1'b1); // slot longer than any label
    send_slot(1'b1, 4'd8, match_ids(1), 1'b0);
    send_slot(1'b0, 4'd0, '1, 1'b0);
    send_slot(1'b1, 4'd8, match_ids(3), 1'b1);
    send_slot(1'b1, 4'd8, '1, 1'b1);
    send_slot(1'b1, 4'd4, '0, 1'b1);
    wait_idle();
    write_label(8'hFF, 4'd0, '0, '0);
    send_slot(1'b1, 4'd0, '0, 1'b1);
    send_slot(1'b0, 4'd8, '1, 1'b1);
    wait_idle();
    // label length above the level count
    write_label(8'h00, 4'd15, '1, 64'h8040_2010_0804_0201);
    send_slot(1'b1, 4'd8, '1, 1'b1);
    send_slot(1'b1, 4'd15, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_slot(1'b1, 4'd7, '1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      random_label(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      // output held off while beats keep coming, so the input backs up
      if (ph == 2)
        hold_cycles = HOLD_OFF_CYCLES;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        random_query();
        n = sb.slots_seen - (ph * ITEMS_PER_PHASE) - 19 > n ? n + 1 : n + 1;
        if (sb.slots_seen >= 19 + (ph + 1) * ITEMS_PER_PHASE)
          n = ITEMS_PER_PHASE;
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d grants never arrived", sb.pending());
      sb.errors += sb.pending();
    end
    $display("%0d slot beats, %0d grants checked under %0d label settings", sb.slots_seen,
             sb.grants_checked, configs_used);
    $display("idle/stall mixes, a %0d-cycle output hold-off, prefix and mismatch depths",
             HOLD_OFF_CYCLES);
    if (sb.errors == 0)
      $display("tb_label_prefix_permission_grant: clean");
    else
      $display("tb_label_prefix_permission_grant: errors");
    $finish;
  end

endmodule
